@@ hdl/sfh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sfh_pkg;

  localparam int unsigned MAX_KEY_LENGTH = 32'd65535;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  // one queued operation for the back end
  typedef struct packed {
    logic        seed_en;
    logic [15:0] seed;
    logic        mix_en;
    logic [15:0] mix_lo;
    logic [15:0] mix_hi;
    logic        fin_en;
    logic        fin_empty;
    logic [23:0] tail;
    logic [1:0]  count;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

@@ hdl/superfasthash_byte_stream_unit.sv @@
// Throughput: one key byte per cycle, sustained, while the result side keeps up.
// After the last byte is queued, the hash passes registers f1 (group mix), f2
// (tail case), f3 and out (two avalanche stages) to reach out_tvalid; result stalls hold it.
// A 4-deep operation queue decouples byte intake from the hash pipeline.
// Reset (rst_n low, synchronous): queue, accumulator, byte gathering and
// all valid flags clear; no result is pending afterward.
`timescale 1ns / 1ps
`default_nettype none

module superfasthash_byte_stream_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // data_byte[7:0], key_length[23:8]
  input  wire logic        in_tuser,   // first_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // hash_value[31:0]
);

  logic             in_accept;
  sfh_pkg::op_t     front_op;
  sfh_pkg::op_t     head_op;
  sfh_pkg::qstat_t  qstat;
  logic             pop;

  assign in_tready = !qstat.full;
  assign in_accept = in_tvalid && in_tready;

  sfh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .data_byte  (in_tdata[7:0]),
    .first_byte (in_tuser),
    .last_byte  (in_tlast),
    .key_length (in_tdata[23:8]),
    .op         (front_op)
  );

  sfh_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_accept),
    .push_op (front_op),
    .pop     (pop),
    .head_op (head_op),
    .stat    (qstat)
  );

  sfh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_op    (head_op),
    .head_valid (!qstat.empty),
    .pop        (pop),
    .hash_valid (out_tvalid),
    .hash_ready (out_tready),
    .hash_value (out_tdata)
  );

  a_queue_flags : assert property (@(posedge clk) disable iff (!rst_n)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty together");

  a_pop_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("back end popped an empty queue");

  a_reset_idle : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("result pending or intake blocked after reset");

endmodule

`default_nettype wire

@@ hdl/sfh_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfh_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         accept,
  input  wire logic [7:0]   data_byte,
  input  wire logic         first_byte,
  input  wire logic         last_byte,
  input  wire logic [15:0]  key_length,
  output sfh_pkg::op_t      op
);

  logic [23:0] pend_r, pend_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic        empty_r, empty_nxt;

  logic [23:0] eff_pend;
  logic [1:0]  eff_pos;
  logic        eff_empty;
  logic [15:0] seed;
  logic [23:0] gath_pend;
  logic [1:0]  gath_pos;

  always_comb begin
    eff_pend  = first_byte ? 24'd0 : pend_r;
    eff_pos   = first_byte ? 2'd0 : pos_r;
    eff_empty = first_byte ? (key_length == 16'd0) : empty_r;

    if ({16'd0, key_length} > sfh_pkg::MAX_KEY_LENGTH) begin
      seed = sfh_pkg::MAX_KEY_LENGTH[15:0];
    end else begin
      seed = key_length;
    end

    op         = '0;
    op.seed_en = first_byte;
    op.seed    = seed;
    gath_pend  = eff_pend;
    gath_pos   = eff_pos;

    if (!eff_empty) begin
      if (eff_pos == 2'd3) begin
        // fourth byte closes the group
        op.mix_en = 1'b1;
        op.mix_lo = eff_pend[15:0];
        op.mix_hi = {data_byte, eff_pend[23:16]};
        gath_pend = 24'd0;
        gath_pos  = 2'd0;
      end else begin
        gath_pend = eff_pend | ({16'd0, data_byte} << {eff_pos, 3'b000});
        gath_pos  = eff_pos + 2'd1;
      end
    end

    op.fin_en    = last_byte;
    op.fin_empty = eff_empty;
    op.tail      = gath_pend;
    op.count     = gath_pos;

    if (last_byte) begin
      pend_nxt  = 24'd0;
      pos_nxt   = 2'd0;
      empty_nxt = 1'b0;
    end else begin
      pend_nxt  = gath_pend;
      pos_nxt   = gath_pos;
      empty_nxt = eff_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 24'd0;
      pos_r   <= 2'd0;
      empty_r <= 1'b0;
    end else if (accept) begin
      pend_r  <= pend_nxt;
      pos_r   <= pos_nxt;
      empty_r <= empty_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/sfh_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfh_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sfh_pkg::op_t  push_op,
  input  wire logic          pop,
  output sfh_pkg::op_t       head_op,
  output sfh_pkg::qstat_t    stat
);

  sfh_pkg::op_t              mem [sfh_pkg::QDEPTH];
  logic [sfh_pkg::QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [sfh_pkg::QAW:0]     count_r, count_nxt;

  assign head_op    = mem[rd_ptr_r];
  assign stat.full  = (count_r == (sfh_pkg::QAW+1)'(sfh_pkg::QDEPTH));
  assign stat.empty = (count_r == '0);

  always_comb begin
    count_nxt = count_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/sfh_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfh_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sfh_pkg::op_t  head_op,
  input  wire logic          head_valid,
  output logic               pop,
  output logic               hash_valid,
  input  wire logic          hash_ready,
  output logic [31:0]        hash_value
);

  function automatic logic [31:0] mix_group(input logic [31:0] h_in,
                                            input logic [15:0] lo,
                                            input logic [15:0] hi);
    logic [31:0] h;
    logic [31:0] t;
    h = h_in + {16'd0, lo};
    t = ({16'd0, hi} << 11) ^ h;
    h = (h << 16) ^ t;
    h = h + (h >> 11);
    return h;
  endfunction

  function automatic logic [31:0] tail_case(input logic [31:0] h_in,
                                            input logic [23:0] b,
                                            input logic [1:0]  cnt);
    logic [31:0] h;
    h = h_in;
    unique case (cnt)
      2'd3: begin
        h = h + {16'd0, b[15:0]};
        h = h ^ (h << 16);
        h = h ^ ({{24{b[23]}}, b[23:16]} << 18);
        h = h + (h >> 11);
      end
      2'd2: begin
        h = h + {16'd0, b[15:0]};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      2'd1: begin
        h = h + {{24{b[7]}}, b[7:0]};
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: h = h_in;
    endcase
    return h;
  endfunction

  logic [31:0] acc_r;
  logic [31:0] h_seed, h_mix;

  logic        f1_v_r, f2_v_r, f3_v_r, out_v_r;
  logic [31:0] f1_h_r, f2_h_r, f3_h_r, out_h_r;
  logic [23:0] f1_tail_r;
  logic [1:0]  f1_cnt_r;
  logic        f1_empty_r;
  logic        out_rdy, f3_rdy, f2_rdy, f1_rdy;
  logic [31:0] f2_h_nxt, f3_h_nxt, out_h_nxt;

  assign out_rdy = !out_v_r || hash_ready;
  assign f3_rdy  = !f3_v_r || out_rdy;
  assign f2_rdy  = !f2_v_r || f3_rdy;
  assign f1_rdy  = !f1_v_r || f2_rdy;

  // a finishing word waits for room in the avalanche pipe
  assign pop = head_valid && (!head_op.fin_en || f1_rdy);

  always_comb begin
    h_seed = head_op.seed_en ? {16'd0, head_op.seed} : acc_r;
    h_mix  = head_op.mix_en ? mix_group(h_seed, head_op.mix_lo, head_op.mix_hi) : h_seed;
  end

  always_comb begin
    f2_h_nxt = f1_empty_r ? 32'd0 : tail_case(f1_h_r, f1_tail_r, f1_cnt_r);

    f3_h_nxt = f2_h_r ^ (f2_h_r << 3);
    f3_h_nxt = f3_h_nxt + (f3_h_nxt >> 5);
    f3_h_nxt = f3_h_nxt ^ (f3_h_nxt << 4);

    out_h_nxt = f3_h_r + (f3_h_r >> 17);
    out_h_nxt = out_h_nxt ^ (out_h_nxt << 25);
    out_h_nxt = out_h_nxt + (out_h_nxt >> 6);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= 32'd0;
      f1_v_r  <= 1'b0;
      f2_v_r  <= 1'b0;
      f3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (pop) begin
        acc_r <= head_op.fin_en ? 32'd0 : h_mix;
      end
      if (f1_rdy) begin
        f1_v_r <= pop && head_op.fin_en;
      end
      if (f2_rdy) begin
        f2_v_r <= f1_v_r;
      end
      if (f3_rdy) begin
        f3_v_r <= f2_v_r;
      end
      if (out_rdy) begin
        out_v_r <= f3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f1_rdy) begin
      f1_h_r     <= h_mix;
      f1_tail_r  <= head_op.tail;
      f1_cnt_r   <= head_op.count;
      f1_empty_r <= head_op.fin_empty;
    end
    if (f2_rdy) begin
      f2_h_r <= f2_h_nxt;
    end
    if (f3_rdy) begin
      f3_h_r <= f3_h_nxt;
    end
    if (out_rdy) begin
      out_h_r <= out_h_nxt;
    end
  end

  assign hash_valid = out_v_r;
  assign hash_value = out_h_r;

endmodule

`default_nettype wire
